>>> rtl/core/kqt_pkg.sv
`default_nettype none

package kqt_pkg;

  // Table geometry.
  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned NAME_CHARS = 19;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  // A key is the three request words packed as {high, mid, low}.
  localparam int unsigned KEY_BYTES = 19;
  localparam int unsigned KEY_BITS  = KEY_BYTES * 8;
  localparam int unsigned QTY_W     = 32;

  // Request codes; the unused code behaves as a query.
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_SET   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  typedef enum logic [1:0] {
    ST_HIT       = 2'd0,
    ST_NEW       = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef logic [KEY_BITS-1:0] key_t;

endpackage

`default_nettype wire

>>> rtl/core/keyed_quantity_table_unit.sv
// Flow: on an empty table an accepted transaction goes straight to the resolve
// state; otherwise the search walks the stored keys until a match or the last one.
// Throughput: one transaction at a time; the sequential scan of the key memory,
// one entry read per cycle, sets the rate.
// Reset: asynchronous and active low; it empties the table by clearing the fill
// count, while the key and quantity memories keep their contents.
`default_nettype none

module keyed_quantity_table_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Request channel.
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [1:0]          req_type_i,
  input  wire logic [63:0]         key_word_low_i,
  input  wire logic [63:0]         key_word_mid_i,
  input  wire logic [23:0]         key_word_high_i,
  input  wire logic signed [31:0]  amount_i,
  // Result channel.
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [1:0]          status_o,
  output      logic signed [31:0]  quantity_out_o
);

  localparam int unsigned IDX_W    = kqt_pkg::IDX_W;
  localparam int unsigned CNT_W    = kqt_pkg::CNT_W;
  localparam int unsigned QTY_W    = kqt_pkg::QTY_W;

  // Sequencer states.
  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SCAN    = 2'd1;
  localparam logic [1:0] S_RESOLVE = 2'd2;

  // --------------------------------------------------------------------------
  // Key normalization. A name ends at its first zero byte or after NAME_CHARS
  // characters; every byte from that point on is forced to zero so that
  // stored and requested keys compare cleanly.
  // --------------------------------------------------------------------------
  kqt_pkg::key_t raw_key;
  kqt_pkg::key_t norm_key;
  logic [kqt_pkg::KEY_BYTES-1:0] ended;

  assign raw_key = {key_word_high_i, key_word_mid_i, key_word_low_i};

  always_comb begin
    norm_key = raw_key;
    for (int k = 0; k < int'(kqt_pkg::KEY_BYTES); k++) begin
      ended[k] = (raw_key[k*8 +: 8] == 8'd0) || (k >= int'(kqt_pkg::NAME_CHARS));
      if (k > 0) begin
        ended[k] = ended[k] || ended[k-1];
      end
      if (ended[k]) begin
        norm_key[k*8 +: 8] = 8'd0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Control and request registers.
  // --------------------------------------------------------------------------
  logic [1:0]              state_q, state_d;
  logic [CNT_W-1:0]        fill_q, fill_d;
  logic [CNT_W-1:0]        issue_idx_q, issue_idx_d;
  logic                    pend_q, pend_d;
  logic [IDX_W-1:0]        pend_idx_q, pend_idx_d;
  logic                    hit_q, hit_d;
  logic [IDX_W-1:0]        hit_idx_q, hit_idx_d;
  logic [QTY_W-1:0]        hit_qty_q, hit_qty_d;
  logic                    out_valid_q, out_valid_d;
  kqt_pkg::status_e        status_q, status_d;
  logic [QTY_W-1:0]        qty_out_q, qty_out_d;

  kqt_pkg::key_t           key_q;
  logic [1:0]              req_q;
  logic [QTY_W-1:0]        amount_q;

  // Memory ports.
  kqt_pkg::key_t           key_mem [kqt_pkg::ENTRIES];
  logic [QTY_W-1:0]        qty_mem [kqt_pkg::ENTRIES];
  kqt_pkg::key_t           key_rd_q;
  logic [QTY_W-1:0]        qty_rd_q;
  logic [IDX_W-1:0]        rd_idx;
  logic                    key_we;
  logic                    qty_we;
  logic [IDX_W-1:0]        wr_idx;
  logic [QTY_W-1:0]        wr_qty;

  logic                    in_fire;
  logic                    out_free;
  logic                    match;
  logic                    table_full;
  logic [QTY_W-1:0]        sum;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // The read address walks the table; the registered data comes back in the next cycle and
  // is compared while the following entry is being read.
  assign rd_idx     = issue_idx_q[IDX_W-1:0];
  assign match      = pend_q && (key_rd_q == key_q);
  assign table_full = (fill_q >= CNT_W'(kqt_pkg::ENTRIES));
  assign sum        = hit_qty_q + amount_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_q    <= norm_key;
      req_q    <= req_type_i;
      amount_q <= amount_i;
    end
  end

  // Key and quantity memories: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_idx] <= key_q;
    end
    if (qty_we) begin
      qty_mem[wr_idx] <= wr_qty;
    end
    key_rd_q <= key_mem[rd_idx];
    qty_rd_q <= qty_mem[rd_idx];
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    issue_idx_d = issue_idx_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_qty_d   = hit_qty_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    qty_out_d   = qty_out_q;
    key_we      = 1'b0;
    qty_we      = 1'b0;
    wr_idx      = hit_idx_q;
    wr_qty      = amount_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          issue_idx_d = '0;
          hit_d       = 1'b0;
          // With an empty table there is nothing to search.
          state_d     = (fill_q == '0) ? S_RESOLVE : S_SCAN;
        end
      end

      S_SCAN: begin
        if (match) begin
          hit_d     = 1'b1;
          hit_idx_d = pend_idx_q;
          hit_qty_d = qty_rd_q;
          state_d   = S_RESOLVE;
        end else if (pend_q && (issue_idx_q == fill_q)) begin
          // The last valid entry has been compared without a match.
          hit_d   = 1'b0;
          state_d = S_RESOLVE;
        end else if (issue_idx_q < fill_q) begin
          pend_d      = 1'b1;
          pend_idx_d  = issue_idx_q[IDX_W-1:0];
          issue_idx_d = issue_idx_q + CNT_W'(1);
        end
      end

      S_RESOLVE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          qty_out_d   = '0;
          priority if (req_q == kqt_pkg::REQ_ADD) begin
            if (hit_q) begin
              qty_we    = 1'b1;
              wr_qty    = sum;
              qty_out_d = sum;
              status_d  = kqt_pkg::ST_HIT;
            end else if (!table_full) begin
              // New entries always go to the first free slot.
              key_we    = 1'b1;
              qty_we    = 1'b1;
              wr_idx    = fill_q[IDX_W-1:0];
              qty_out_d = amount_q;
              fill_d    = fill_q + CNT_W'(1);
              status_d  = kqt_pkg::ST_NEW;
            end else begin
              status_d  = kqt_pkg::ST_FULL;
            end
          end else if (req_q == kqt_pkg::REQ_SET) begin
            if (hit_q) begin
              qty_we    = 1'b1;
              qty_out_d = amount_q;
              status_d  = kqt_pkg::ST_HIT;
            end else begin
              status_d  = kqt_pkg::ST_NOT_FOUND;
            end
          end else begin
            if (hit_q) begin
              qty_out_d = hit_qty_q;
              status_d  = kqt_pkg::ST_HIT;
            end else begin
              status_d  = kqt_pkg::ST_NOT_FOUND;
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      issue_idx_q <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      out_valid_q <= 1'b0;
      status_q    <= kqt_pkg::ST_HIT;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      issue_idx_q <= issue_idx_d;
      pend_q      <= pend_d;
      pend_idx_q  <= pend_idx_d;
      hit_q       <= hit_d;
      hit_idx_q   <= hit_idx_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_qty_q <= hit_qty_d;
    qty_out_q <= qty_out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign quantity_out_o = qty_out_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(kqt_pkg::ENTRIES))
    else $error("fill count exceeds the table size");

  a_fill_grows_on_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |->
      (status_q == kqt_pkg::ST_NEW && out_valid_q && fill_q == $past(fill_q) + CNT_W'(1)))
    else $error("fill count changed without a new entry result");

  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_SCAN))
    else $error("memory compare pending outside the scan");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESOLVE && hit_q) |-> (CNT_W'(hit_idx_q) < fill_q))
    else $error("hit index points past the filled entries");

  a_result_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESOLVE && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("resolved transaction did not load the result register");

endmodule

`default_nettype wire

>>> sim/keyed_quantity_table_unit_tb.sv
`timescale 1ns / 1ps

module keyed_quantity_table_unit_tb;

  // Number of random requests that follow the directed table.
  localparam int RANDOM_ITEMS = 2000;
  // Extra names in the random pool that are never stored in the table.
  localparam int ABSENT_NAMES = 8;

  // One request as the stimulus sees it. When fixed is set, the expected
  // result is typed into the row; otherwise the table model supplies it.
  typedef struct {
    logic [1:0]                kind;
    kqt_pkg::key_t             name;
    logic [kqt_pkg::QTY_W-1:0] amount;
    bit                        fixed;
    kqt_pkg::status_e          want_status;
    logic [kqt_pkg::QTY_W-1:0] want_qty;
  } request_t;

  typedef struct packed {
    kqt_pkg::status_e          status;
    logic [kqt_pkg::QTY_W-1:0] quantity;
  } outcome_t;

  logic                             clk_i           = 1'b0;
  logic                             rst_ni          = 1'b0;
  logic                             in_valid_i      = 1'b0;
  logic                             in_stall_o;
  logic [1:0]                       req_type_i      = kqt_pkg::REQ_QUERY;
  logic [63:0]                      key_word_low_i  = '0;
  logic [63:0]                      key_word_mid_i  = '0;
  logic [23:0]                      key_word_high_i = '0;
  logic signed [kqt_pkg::QTY_W-1:0] amount_i        = '0;
  logic                             out_valid_o;
  logic                             out_stall_i     = 1'b0;
  logic [1:0]                       status_o;
  logic signed [kqt_pkg::QTY_W-1:0] quantity_out_o;

  // Our own copy of the table: stored names (already cut at their
  // terminator), their quantities and how many slots are in use.
  kqt_pkg::key_t             table_names [kqt_pkg::ENTRIES];
  logic [kqt_pkg::QTY_W-1:0] table_qty   [kqt_pkg::ENTRIES];
  int                        table_fill = 0;

  // Results predicted for accepted requests, oldest first.
  outcome_t pending_outcomes [$];

  int  mismatch_count  = 0;
  int  results_checked = 0;
  int  offered_count   = 0;
  bit  long_hold_done  = 1'b0;

  keyed_quantity_table_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .key_word_low_i (key_word_low_i),
    .key_word_mid_i (key_word_mid_i),
    .key_word_high_i(key_word_high_i),
    .amount_i       (amount_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .quantity_out_o (quantity_out_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs or drops a transaction.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Packs a string with its first character in the lowest byte, the way the
  // three key words expect it.
  function automatic kqt_pkg::key_t pack_name(input string s);
    kqt_pkg::key_t k;
    int            b;
    k = '0;
    for (b = 0; b < s.len() && b < kqt_pkg::KEY_BYTES; b++) begin
      k[b*8 +: 8] = s[b];
    end
    return k;
  endfunction

  // A name ends at its first zero byte or after NAME_CHARS characters.
  // Everything beyond that point is cleared so that trailing junk neither
  // matches nor gets stored.
  function automatic kqt_pkg::key_t canonical_name(input kqt_pkg::key_t raw);
    kqt_pkg::key_t k;
    bit            ended;
    int            b;
    k = raw;
    ended = 1'b0;
    for (b = 0; b < kqt_pkg::KEY_BYTES; b++) begin
      if (b >= kqt_pkg::NAME_CHARS) ended = 1'b1;
      if (!ended && k[b*8 +: 8] == 8'h00) ended = 1'b1;
      if (ended) k[b*8 +: 8] = 8'h00;
    end
    return k;
  endfunction

  // Applies one request to the table copy and returns the result that the
  // block must produce for it. Sums wrap at 32 bits by the vector width.
  function automatic outcome_t apply_request(input logic [1:0] kind,
                                             input kqt_pkg::key_t raw,
                                             input logic [kqt_pkg::QTY_W-1:0] amt);
    kqt_pkg::key_t name;
    int            hit;
    int            i;
    outcome_t      res;
    name = canonical_name(raw);
    hit = -1;
    for (i = 0; i < table_fill; i++) begin
      if (hit < 0 && table_names[i] == name) hit = i;
    end
    res.status = kqt_pkg::ST_NOT_FOUND;
    res.quantity = '0;
    case (kind)
      kqt_pkg::REQ_ADD: begin
        if (hit >= 0) begin
          table_qty[hit] = table_qty[hit] + amt;
          res.status = kqt_pkg::ST_HIT;
          res.quantity = table_qty[hit];
        end else if (table_fill < kqt_pkg::ENTRIES) begin
          table_names[table_fill] = name;
          table_qty[table_fill] = amt;
          table_fill++;
          res.status = kqt_pkg::ST_NEW;
          res.quantity = amt;
        end else begin
          res.status = kqt_pkg::ST_FULL;
        end
      end
      kqt_pkg::REQ_SET: begin
        if (hit >= 0) begin
          table_qty[hit] = amt;
          res.status = kqt_pkg::ST_HIT;
          res.quantity = amt;
        end
      end
      // Query, and the unused code, which the block treats as a query.
      default: begin
        if (hit >= 0) begin
          res.status = kqt_pkg::ST_HIT;
          res.quantity = table_qty[hit];
        end
      end
    endcase
    return res;
  endfunction

  function automatic request_t make_row(input logic [1:0] kind, input kqt_pkg::key_t name,
                                        input logic [kqt_pkg::QTY_W-1:0] amt,
                                        input bit fixed = 1'b0,
                                        input kqt_pkg::status_e st = kqt_pkg::ST_HIT,
                                        input logic [kqt_pkg::QTY_W-1:0] qty = '0);
    request_t r;
    r.kind = kind;
    r.name = name;
    r.amount = amt;
    r.fixed = fixed;
    r.want_status = st;
    r.want_qty = qty;
    return r;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Every fourth block of 128 transactions is sent back to back.
  function automatic int unsigned sender_gap();
    if ((offered_count / 128) % 4 == 3) return 0;
    if ($urandom_range(0, 1) == 0) return 0;
    return idle_length();
  endfunction

  // Fills every byte after the terminator with junk; the block must ignore it.
  function automatic kqt_pkg::key_t smear_tail(input kqt_pkg::key_t k);
    logic [159:0] noise;
    bit           past;
    int           b;
    noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    past = 1'b0;
    for (b = 0; b < kqt_pkg::KEY_BYTES; b++) begin
      if (past) k[b*8 +: 8] = noise[b*8 +: 8];
      else if (k[b*8 +: 8] == 8'h00) past = 1'b1;
    end
    return k;
  endfunction

  // A random name of one to NAME_CHARS characters with no zero byte inside.
  function automatic kqt_pkg::key_t random_name();
    kqt_pkg::key_t k;
    int            len;
    int            b;
    k = '0;
    len = $urandom_range(1, kqt_pkg::NAME_CHARS);
    for (b = 0; b < len; b++) k[b*8 +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  // Most random requests use names from the pool, so that hits, sums and
  // overwrites dominate; a tenth are raw random key words.
  function automatic request_t random_request(ref kqt_pkg::key_t pool[$]);
    request_t     r;
    logic [159:0] noise;
    int unsigned  pick;
    r.fixed = 1'b0;
    r.want_status = kqt_pkg::ST_HIT;
    r.want_qty = '0;
    if ($urandom_range(0, 9) == 0) begin
      noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      r.name = noise[kqt_pkg::KEY_BITS-1:0];
      r.kind = 2'($urandom_range(0, 3));
    end else begin
      if ($urandom_range(0, 4) != 0) r.name = pool[$urandom_range(0, kqt_pkg::ENTRIES - 1)];
      else r.name = pool[$urandom_range(kqt_pkg::ENTRIES, pool.size() - 1)];
      if ($urandom_range(0, 1) == 0) r.name = smear_tail(r.name);
      pick = $urandom_range(0, 99);
      if (pick < 40) r.kind = kqt_pkg::REQ_ADD;
      else if (pick < 65) r.kind = kqt_pkg::REQ_SET;
      else if (pick < 95) r.kind = kqt_pkg::REQ_QUERY;
      else r.kind = 2'd3;
    end
    pick = $urandom_range(0, 9);
    case (pick)
      0: r.amount = 32'h7FFF_FFFF;
      1: r.amount = 32'h8000_0000;
      2: r.amount = 32'hFFFF_FFFF;
      default: r.amount = $urandom();
    endcase
    return r;
  endfunction

  // Offers one transaction after an optional pause and waits until it is
  // taken. The expected result is queued at the edge that accepts it. The
  // valid line is only lowered when a real pause follows, so it never drops
  // and rises again in the same time step.
  task automatic offer_request(input request_t r);
    outcome_t    predicted;
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_type_i      <= r.kind;
    key_word_low_i  <= r.name[63:0];
    key_word_mid_i  <= r.name[127:64];
    key_word_high_i <= r.name[151:128];
    amount_i        <= r.amount;
    in_valid_i      <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = apply_request(r.kind, r.name, r.amount);
    if (r.fixed) begin
      predicted.status = r.want_status;
      predicted.quantity = r.want_qty;
    end
    pending_outcomes.push_back(predicted);
    offered_count++;
    @(negedge clk_i);
  endtask

  // Result side: stalls come in runs of random length. Once, after a few
  // hundred results, the stall is held for a long stretch while the sender
  // keeps offering, so the block backs up and stalls its own input.
  initial begin : result_stall
    int unsigned run;
    bit          hold;
    @(negedge clk_i);
    forever begin
      if (!long_hold_done && results_checked >= 300) begin
        long_hold_done = 1'b1;
        hold = 1'b1;
        run = 400;
      end else if ($urandom_range(0, 3) == 0) begin
        hold = 1'b1;
        run = idle_length();
      end else begin
        hold = 1'b0;
        run = $urandom_range(1, 40);
      end
      out_stall_i <= hold;
      repeat (run) @(negedge clk_i);
    end
  end

  // Every result taken at a rising edge is compared with the oldest
  // prediction, one field at a time.
  always @(posedge clk_i) begin : result_check
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        flag_mismatch($sformatf("unexpected result status %0d quantity %0d",
                                status_o, quantity_out_o));
      end else begin
        want = pending_outcomes.pop_front();
        if (status_o !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (quantity_out_o !== want.quantity)
          flag_mismatch($sformatf("quantity %0d, expected %0d", quantity_out_o,
                                  $signed(want.quantity)));
        results_checked++;
      end
    end
  end

  initial begin : stimulus
    request_t      rows [$];
    kqt_pkg::key_t pool [$];
    kqt_pkg::key_t ones;
    int            i;

    ones = '1;

    // Directed table. Expected results are spelled out where they are
    // obvious; the table fill rows are left to the model.
    // Query on an empty table finds nothing.
    rows.push_back(make_row(kqt_pkg::REQ_QUERY, pack_name(""), 32'd0, 1,
                            kqt_pkg::ST_NOT_FOUND, 32'd0));
    // The empty name is a normal name.
    rows.push_back(make_row(kqt_pkg::REQ_ADD, pack_name(""), 32'd7, 1, kqt_pkg::ST_NEW,
                            32'd7));
    // Positive overflow wraps to the most negative value and back.
    rows.push_back(make_row(kqt_pkg::REQ_ADD, pack_name("apple"), 32'h7FFF_FFFF, 1,
                            kqt_pkg::ST_NEW, 32'h7FFF_FFFF));
    rows.push_back(make_row(kqt_pkg::REQ_ADD, pack_name("apple"), 32'd1, 1,
                            kqt_pkg::ST_HIT, 32'h8000_0000));
    rows.push_back(make_row(kqt_pkg::REQ_ADD, pack_name("apple"), 32'hFFFF_FFFF, 1,
                            kqt_pkg::ST_HIT, 32'h7FFF_FFFF));
    // Negative overflow: two most negative values sum to zero.
    rows.push_back(make_row(kqt_pkg::REQ_ADD, pack_name("berry"), 32'h8000_0000, 1,
                            kqt_pkg::ST_NEW, 32'h8000_0000));
    rows.push_back(make_row(kqt_pkg::REQ_ADD, pack_name("berry"), 32'h8000_0000, 1,
                            kqt_pkg::ST_HIT, 32'd0));
    rows.push_back(make_row(kqt_pkg::REQ_SET, pack_name("berry"), -32'sd123, 1,
                            kqt_pkg::ST_HIT, -32'sd123));
    // The spare request code reads like a query and ignores the amount.
    rows.push_back(make_row(2'd3, pack_name("berry"), 32'd55, 1, kqt_pkg::ST_HIT,
                            -32'sd123));
    // Junk after the terminator is dropped before storing and comparing.
    rows.push_back(make_row(kqt_pkg::REQ_ADD,
                            pack_name("kiwi") | (kqt_pkg::key_t'(40'hA5_C30F_1E77) << 48),
                            32'd42, 1, kqt_pkg::ST_NEW, 32'd42));
    rows.push_back(make_row(kqt_pkg::REQ_QUERY, pack_name("kiwi"), 32'd0, 1,
                            kqt_pkg::ST_HIT, 32'd42));
    rows.push_back(make_row(kqt_pkg::REQ_SET,
                            pack_name("kiwi") | (kqt_pkg::key_t'(32'h0101_0101) << 120),
                            32'd9, 1, kqt_pkg::ST_HIT, 32'd9));
    // Full-length name, and a name one character shorter that must not match.
    rows.push_back(make_row(kqt_pkg::REQ_ADD, pack_name("abcdefghijklmnopqrs"), 32'd100, 1,
                            kqt_pkg::ST_NEW, 32'd100));
    rows.push_back(make_row(kqt_pkg::REQ_QUERY, pack_name("abcdefghijklmnopqr"), 32'd0, 1,
                            kqt_pkg::ST_NOT_FOUND, 32'd0));
    rows.push_back(make_row(kqt_pkg::REQ_ADD, pack_name("abcdefghijklmnop"), 32'd0));
    // Every key bit set.
    rows.push_back(make_row(kqt_pkg::REQ_ADD, ones, 32'hFFFF_FFFF, 1, kqt_pkg::ST_NEW,
                            32'hFFFF_FFFF));
    rows.push_back(make_row(kqt_pkg::REQ_QUERY, ones, 32'hFFFF_FFFF, 1, kqt_pkg::ST_HIT,
                            32'hFFFF_FFFF));
    // Fill the remaining slots.
    for (i = 0; i < kqt_pkg::ENTRIES - 7; i++) begin
      rows.push_back(make_row(kqt_pkg::REQ_ADD, pack_name($sformatf("slot%0d", i)),
                              $urandom()));
    end
    // A new name on a full table is dropped; a set of it finds nothing.
    rows.push_back(make_row(kqt_pkg::REQ_ADD, pack_name("melon"), 32'd5, 1,
                            kqt_pkg::ST_FULL, 32'd0));
    rows.push_back(make_row(kqt_pkg::REQ_SET, pack_name("melon"), 32'd5, 1,
                            kqt_pkg::ST_NOT_FOUND, 32'd0));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[n]) offer_request(rows[n]);

    // Random part: the pool holds every stored name first, then names that
    // were never stored.
    for (i = 0; i < kqt_pkg::ENTRIES; i++) pool.push_back(table_names[i]);
    for (i = 0; i < ABSENT_NAMES; i++) pool.push_back(random_name());
    for (i = 0; i < RANDOM_ITEMS; i++) offer_request(random_request(pool));
    in_valid_i <= 1'b0;

    // Drain, then give a stray result time to show up.
    wait (pending_outcomes.size() == 0);
    repeat (kqt_pkg::ENTRIES + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/kqt_pkg.sv
rtl/core/keyed_quantity_table_unit.sv
sim/keyed_quantity_table_unit_tb.sv
